[design/crs_pkg.sv]
// crs_pkg: shared constants, types and codes of the range sum counter
`timescale 1ns / 1ps

package crs_pkg;

    // capacity and field widths
    localparam int MAX_ITEMS = 256;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = DATA_W + $clog2(MAX_ITEMS);
    localparam int BOUND_W   = SUM_W + 1;
    localparam int FILL_W    = $clog2(MAX_ITEMS + 1);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 2);
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 1;

    typedef logic [FILL_W-1:0]          t_fill;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [BOUND_W-1:0]  t_bound;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    // fill level at which the prefix row is full
    localparam t_fill FILL_MAX = FILL_W'(MAX_ITEMS);

    // configuration register indexes
    localparam t_cfg_idx REG_WINDOW_LOW  = CFG_IDX_W'(0);
    localparam t_cfg_idx REG_WINDOW_HIGH = CFG_IDX_W'(1);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUND,
        S_SCAN,
        S_UPDATE,
        S_EMIT
    } t_state;

    // broadcast from the sequencer to every cell of the row
    typedef struct packed {
        logic   wr_en;
        t_fill  wr_idx;
        t_sum   wr_data;
        t_bound lo;
        t_bound hi;
        t_fill  fill;
    } t_bcast;

endpackage

[design/crs_in_if.sv]
// crs_in_if: input element channel
`timescale 1ns / 1ps

interface crs_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [crs_pkg::DATA_W-1:0] value;
    logic                             first;
    logic                             last;

    modport source (output valid, output value, output first, output last, input ready);
    modport sink (input valid, input value, input first, input last, output ready);
endinterface

[design/crs_out_if.sv]
// crs_out_if: result channel
`timescale 1ns / 1ps

interface crs_out_if;
    logic                         valid;
    logic                         ready;
    logic [crs_pkg::COUNT_W-1:0]  range_count;
    logic                         done_res;
    logic                         overflow;

    modport source (output valid, output range_count, output done_res, output overflow,
                    input ready);
    modport sink (input valid, input range_count, input done_res, input overflow,
                  output ready);
endinterface

[design/crs_cell.sv]
// crs_cell: one stored prefix, its window match and one stage of the count ripple
`timescale 1ns / 1ps

module crs_cell (
    input  logic              i_clk,
    input  crs_pkg::t_bcast   i_bcast,
    input  crs_pkg::t_fill    i_idx,
    input  crs_pkg::t_cnt     i_count,
    output crs_pkg::t_cnt     o_count
);

    crs_pkg::t_sum   r_prefix;
    crs_pkg::t_cnt   r_count;
    crs_pkg::t_bound w_prefix_ext;
    logic            w_hit;

    // prefix store, written when the broadcast addresses this cell
    always_ff @(posedge i_clk) begin
        if (i_bcast.wr_en && (i_bcast.wr_idx == i_idx)) begin
            r_prefix <= i_bcast.wr_data;
        end
    end

    // match: cell holds a live prefix inside [lo, hi]
    assign w_prefix_ext = {r_prefix[crs_pkg::SUM_W-1], r_prefix};
    assign w_hit = (i_idx <= i_bcast.fill)
                && ($signed(w_prefix_ext) >= $signed(i_bcast.lo))
                && ($signed(w_prefix_ext) <= $signed(i_bcast.hi));

    // running count handed on to the next cell
    always_ff @(posedge i_clk) begin
        r_count <= i_count + crs_pkg::t_cnt'(w_hit);
    end

    assign o_count = r_count;

endmodule

[design/count_range_sums.sv]
// count_range_sums: top level, sequencer and row of prefix cells
`timescale 1ns / 1ps

// Counts the subarrays of a signed element sequence whose sum lies in the inclusive
// window [window_low, window_high] and returns the running count once per element.
// Every prefix sum lives in its own cell of a row of MAX_ITEMS+1 cells; the new prefix
// turns into a pair of bounds that all cells compare at once, and the matches are summed
// by a count that ripples one cell per clock down the row. An element passes through an
// accept step, a bound step, the ripple down the row, an update and the load of the
// result register before the sequencer is ready again; that load waits until a held result
// is taken. An element that arrives with the row full skips the bound, ripple and update
// steps and only flags overflow. The result register holds one finished transaction, so
// the next element is taken while a result still waits.
module count_range_sums (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    crs_in_if.sink                      i_item,
    crs_out_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  crs_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [crs_pkg::DATA_W-1:0]  i_cfg_data
);

    localparam int NCELL = crs_pkg::MAX_ITEMS + 1;

    crs_pkg::t_state r_state;
    crs_pkg::t_state n_state;

    logic signed [crs_pkg::DATA_W-1:0] r_win_lo;
    logic signed [crs_pkg::DATA_W-1:0] r_win_hi;
    crs_pkg::t_sum                     r_sum;
    crs_pkg::t_sum                     r_s;
    crs_pkg::t_fill                    r_fill;
    crs_pkg::t_fill                    r_scan;
    logic [crs_pkg::COUNT_W-1:0]       r_total;
    logic                              r_ovf;
    logic                              r_last;
    crs_pkg::t_bound                   r_lo;
    crs_pkg::t_bound                   r_hi;

    logic                              r_out_valid;
    logic [crs_pkg::COUNT_W-1:0]       r_out_count;
    logic                              r_out_done;
    logic                              r_out_ovf;

    logic                              w_in_acc;
    logic                              w_out_free;
    logic                              w_full;
    crs_pkg::t_sum                     w_sum_eff;
    crs_pkg::t_sum                     w_value_ext;
    crs_pkg::t_bound                   w_s_ext;
    logic [crs_pkg::COUNT_W:0]         w_total_sum;
    crs_pkg::t_bcast                   w_bcast;
    crs_pkg::t_cnt                     w_chain [0:NCELL];

    // handshake
    assign i_item.ready = (r_state == crs_pkg::S_IDLE);
    assign w_in_acc     = i_item.valid && (r_state == crs_pkg::S_IDLE);
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_full       = !i_item.first && (r_fill >= crs_pkg::FILL_MAX);

    // new prefix from the incoming element
    assign w_sum_eff   = i_item.first ? '0 : r_sum;
    assign w_value_ext = {{(crs_pkg::SUM_W - crs_pkg::DATA_W){i_item.value[crs_pkg::DATA_W-1]}},
                          i_item.value};
    assign w_s_ext     = {r_s[crs_pkg::SUM_W-1], r_s};
    assign w_total_sum = {1'b0, r_total} + (crs_pkg::COUNT_W + 1)'(w_chain[NCELL]);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            crs_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_full ? crs_pkg::S_EMIT : crs_pkg::S_BOUND;
                end
            end
            crs_pkg::S_BOUND: begin
                n_state = crs_pkg::S_SCAN;
            end
            crs_pkg::S_SCAN: begin
                if (r_scan == crs_pkg::FILL_MAX) begin
                    n_state = crs_pkg::S_UPDATE;
                end
            end
            crs_pkg::S_UPDATE: begin
                n_state = crs_pkg::S_EMIT;
            end
            crs_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_state = crs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = crs_pkg::S_IDLE;
            end
        endcase
    end

    // broadcast to the cell row: empty prefix on reset or new sequence, new prefix in the update state
    always_comb begin
        w_bcast.lo   = r_lo;
        w_bcast.hi   = r_hi;
        w_bcast.fill = r_fill;
        if (!i_rst_n || (w_in_acc && i_item.first)) begin
            w_bcast.wr_en   = 1'b1;
            w_bcast.wr_idx  = '0;
            w_bcast.wr_data = '0;
        end else if (r_state == crs_pkg::S_UPDATE) begin
            w_bcast.wr_en   = 1'b1;
            w_bcast.wr_idx  = crs_pkg::t_fill'(r_fill + 1'b1);
            w_bcast.wr_data = r_s;
        end else begin
            w_bcast.wr_en   = 1'b0;
            w_bcast.wr_idx  = '0;
            w_bcast.wr_data = r_s;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_lo <= '0;
            r_win_hi <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crs_pkg::REG_WINDOW_LOW:  r_win_lo <= i_cfg_data;
                crs_pkg::REG_WINDOW_HIGH: r_win_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_fill  <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                crs_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_item.first) begin
                            r_sum   <= '0;
                            r_fill  <= '0;
                            r_total <= '0;
                            r_ovf   <= 1'b0;
                        end else if (w_full) begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                crs_pkg::S_UPDATE: begin
                    r_total <= w_total_sum[crs_pkg::COUNT_W] ? '1
                                                              : w_total_sum[crs_pkg::COUNT_W-1:0];
                    r_sum   <= r_s;
                    r_fill  <= crs_pkg::t_fill'(r_fill + 1'b1);
                end
                default: ;
            endcase
        end
    end

    // working registers of the current element
    always_ff @(posedge i_clk) begin
        case (r_state)
            crs_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_s    <= w_sum_eff + w_value_ext;
                    r_last <= i_item.last;
                end
            end
            crs_pkg::S_BOUND: begin
                // window on the earlier prefix: s - high <= p <= s - low
                r_lo   <= w_s_ext - crs_pkg::t_bound'(r_win_hi);
                r_hi   <= w_s_ext - crs_pkg::t_bound'(r_win_lo);
                r_scan <= '0;
            end
            crs_pkg::S_SCAN: begin
                r_scan <= crs_pkg::t_fill'(r_scan + 1'b1);
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == crs_pkg::S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == crs_pkg::S_EMIT) && w_out_free) begin
            r_out_count <= r_total;
            r_out_done  <= r_last;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.range_count = r_out_count;
    assign o_res.done_res    = r_out_done;
    assign o_res.overflow    = r_out_ovf;

    // row of prefix cells, match count rippling toward the tail
    assign w_chain[0] = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        crs_cell u_cell (
            .i_clk   (i_clk),
            .i_bcast (w_bcast),
            .i_idx   (crs_pkg::t_fill'(k)),
            .i_count (w_chain[k]),
            .o_count (w_chain[k+1])
        );
    end

endmodule
